### rtl/cursor_glyph_normalizer_defines.svh
// assertion macros shared by the cursor glyph normalizer
`ifndef CURSOR_GLYPH_NORMALIZER_DEFINES_SVH
`define CURSOR_GLYPH_NORMALIZER_DEFINES_SVH

// same-cycle implication
`define CGN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CGN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cgn_pkg.sv
// package with payload types, codes and defaults of the cursor glyph normalizer
`timescale 1ns / 1ps

package cgn_pkg;

    localparam int MAX_SIDE_DEF = 128;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int ALPHA_LSB    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_SIDE  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CANVAS_RESET = 8'd96;
    localparam logic [CFG_DATA_W-1:0] GLYPH_RESET  = 8'd0;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  source_width;
        logic [7:0]  source_height;
        logic [6:0]  hotspot_x;
        logic [6:0]  hotspot_y;
        logic [31:0] source_pixel;
        logic        last_pixel;
        logic [6:0]  read_col;
        logic [6:0]  read_row;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic        rescaled;
        logic [7:0]  image_width;
        logic [7:0]  image_height;
        logic [6:0]  out_hot_x;
        logic [6:0]  out_hot_y;
        logic [31:0] pixel_out;
    } t_out_item;

endpackage

### rtl/cgn_stream_if.sv
// valid/ready stream interface carrying one payload per transaction
`timescale 1ns / 1ps

interface cgn_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/cursor_glyph_normalizer.sv
// cursor glyph normalizer top level: image store, bounds scan, shared divider, box filter
// load: one transaction per cycle while the output is not stalled; read: registered memory read, then
// output register; last load: bounds scan through the source memory read port, then, if the box
// exceeds a nonzero glyph side, the header rescale adds 4 divisions; each output row adds one and
// each output pixel 5 divisions, a read and an accumulate step per box pixel and one canvas write
// synchronous active-low reset clears control and header; no clearing pass is needed
`timescale 1ns / 1ps
`include "cursor_glyph_normalizer_defines.svh"

module cursor_glyph_normalizer
    import cgn_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cgn_stream_if.sink            i_in,
    cgn_stream_if.source          o_out
);

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int XW    = (SW > 8) ? SW : 8;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = AW + 1;
    localparam int ACW   = AW + 8;
    localparam int DNW   = AW + 10;
    localparam int DDW   = AW + 2;
    localparam int DCW   = $clog2(DNW);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RDOUT   = 5'd1;
    localparam logic [4:0] S_SCAN_RD = 5'd2;
    localparam logic [4:0] S_SCAN_CK = 5'd3;
    localparam logic [4:0] S_DECIDE  = 5'd4;
    localparam logic [4:0] S_DIV     = 5'd5;
    localparam logic [4:0] S_SC_H    = 5'd6;
    localparam logic [4:0] S_SC_HX   = 5'd7;
    localparam logic [4:0] S_SC_HY   = 5'd8;
    localparam logic [4:0] S_FIX     = 5'd9;
    localparam logic [4:0] S_ROW_Y1  = 5'd10;
    localparam logic [4:0] S_ROW_SET = 5'd11;
    localparam logic [4:0] S_COL_X1  = 5'd12;
    localparam logic [4:0] S_COL_SET = 5'd13;
    localparam logic [4:0] S_ACC_RD  = 5'd14;
    localparam logic [4:0] S_ACC_AD  = 5'd15;
    localparam logic [4:0] S_CH_DIV  = 5'd16;
    localparam logic [4:0] S_CH_SET  = 5'd17;
    localparam logic [4:0] S_CAN_WR  = 5'd18;
    localparam logic [4:0] S_HDR     = 5'd19;

    typedef struct packed {
        logic [4:0]           ret;
        logic [LW-1:0]        load_cnt;
        logic [XW-1:0]        src_w;
        logic [XW-1:0]        src_h;
        logic [XW-1:0]        src_hx;
        logic [XW-1:0]        src_hy;
        logic [XW-1:0]        c;
        logic [XW-1:0]        g;
        logic                 seen;
        logic [XW-1:0]        minx;
        logic [XW-1:0]        maxx;
        logic [XW-1:0]        miny;
        logic [XW-1:0]        maxy;
        logic [XW-1:0]        sx;
        logic [XW-1:0]        sy;
        logic [AW-1:0]        addr;
        logic [XW-1:0]        len;
        logic [XW-1:0]        dw;
        logic [XW-1:0]        dh;
        logic                 rescaled;
        logic [XW-1:0]        hdr_w;
        logic [XW-1:0]        hdr_h;
        logic [XW-1:0]        hdr_hx;
        logic [XW-1:0]        hdr_hy;
        logic [XW-1:0]        dx;
        logic [XW-1:0]        dy;
        logic [XW-1:0]        x;
        logic [XW-1:0]        y;
        logic [XW-1:0]        x0;
        logic [XW-1:0]        x1;
        logic [XW-1:0]        y0;
        logic [XW-1:0]        y1;
        logic [XW-1:0]        x0raw;
        logic [XW-1:0]        y0raw;
        logic [XW-1:0]        x1raw;
        logic [XW-1:0]        y1raw;
        logic [AW-1:0]        rowbase;
        logic [3:0][ACW-1:0]  acc;
        logic [LW-1:0]        n;
        logic [1:0]           k;
        logic [3:0][7:0]      pix;
        logic [DNW-1:0]       dv_num;
        logic [DDW-1:0]       dv_den;
        logic [DDW-1:0]       dv_rem;
        logic [DCW-1:0]       dv_cnt;
        logic                 rd_in;
        logic                 rd_can;
        logic                 out_valid;
        t_out_item            out;
    } t_ctx;

    function automatic logic [XW-1:0] clamp_side(input logic [7:0] v);
        logic [XW-1:0] e;
        e = XW'(v);
        if (v == 8'd0) e = XW'(1);
        else if (e > XW'(MAX_SIDE)) e = XW'(MAX_SIDE);
        return e;
    endfunction

    function automatic logic [XW-1:0] fit_side(input logic [DNW-1:0] q, input logic [XW-1:0] c);
        logic [XW-1:0] v;
        if (q == '0) v = XW'(1);
        else if (q > DNW'(c)) v = c;
        else v = XW'(q);
        return v;
    endfunction

    function automatic logic [XW-1:0] fit_hot(input logic [DNW-1:0] q, input logic [XW-1:0] c);
        return (q >= DNW'(c)) ? c - XW'(1) : XW'(q);
    endfunction

    function automatic logic [XW-1:0] fit_bound(input logic [DNW-1:0] raw,
                                                input logic [XW-1:0] lo,
                                                input logic [XW-1:0] lim);
        logic [DNW-1:0] v;
        v = (raw <= DNW'(lo)) ? DNW'(lo) + DNW'(1) : raw;
        if (v > DNW'(lim)) v = DNW'(lim);
        return XW'(v);
    endfunction

    function automatic logic [DNW-1:0] scale_num(input logic [XW-1:0] a,
                                                 input logic [XW-1:0] g,
                                                 input logic [XW-1:0] len);
        return ((DNW'(a) * DNW'(g)) << 1) + DNW'(len);
    endfunction

    logic [4:0]         r_state, n_state;
    t_ctx               r_ctx, n_ctx;
    logic [7:0]         r_canvas, r_glyph;
    logic [31:0]        src_mem [DEPTH];
    logic [31:0]        can_mem [DEPTH];
    logic [31:0]        r_src_q, r_can_q;
    logic [AW-1:0]      src_rd_addr, can_rd_addr, can_wr_addr;
    logic               can_we, src_we;
    logic               in_rdy, in_acc;
    logic               dv_go;
    logic [DNW-1:0]     dv_n;
    logic [DDW-1:0]     dv_d;
    logic [4:0]         dv_r;
    logic [DDW:0]       dv_trial;
    logic               dv_ge;
    logic [XW-1:0]      bw, bh, len_c, c_c, g_c, gx;
    logic [XW-1:0]      rd_col, rd_row;

    assign in_rdy      = (r_state == S_IDLE) && (!r_ctx.out_valid || o_out.ready);
    assign in_acc      = i_in.valid && in_rdy;
    assign i_in.ready  = in_rdy;
    assign o_out.valid = r_ctx.out_valid;
    assign o_out.payload = r_ctx.out;

    assign rd_col      = XW'(i_in.payload.read_col);
    assign rd_row      = XW'(i_in.payload.read_row);
    assign can_rd_addr = AW'(rd_row) * AW'(MAX_SIDE) + AW'(rd_col);
    assign can_wr_addr = AW'(r_ctx.dy) * AW'(MAX_SIDE) + AW'(r_ctx.dx);
    assign src_we      = in_acc && (i_in.payload.opcode == OP_LOAD)
                         && (r_ctx.load_cnt < LW'(DEPTH));

    assign c_c   = clamp_side(r_canvas);
    assign gx    = XW'(r_glyph);
    assign g_c   = (gx > c_c) ? c_c : gx;
    assign bw    = r_ctx.maxx - r_ctx.minx + XW'(1);
    assign bh    = r_ctx.maxy - r_ctx.miny + XW'(1);
    assign len_c = (bw > bh) ? bw : bh;

    assign dv_trial = {r_ctx.dv_rem, r_ctx.dv_num[DNW-1]};
    assign dv_ge    = dv_trial >= {1'b0, r_ctx.dv_den};

    always_comb begin
        n_state     = r_state;
        n_ctx       = r_ctx;
        dv_go       = 1'b0;
        dv_n        = '0;
        dv_d        = '0;
        dv_r        = S_IDLE;
        can_we      = 1'b0;
        src_rd_addr = r_ctx.addr;
        if (o_out.ready) n_ctx.out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                src_rd_addr = AW'(rd_row) * AW'(r_ctx.hdr_w) + AW'(rd_col);
                if (in_acc) begin
                    if (i_in.payload.opcode == OP_LOAD) begin
                        if (r_ctx.load_cnt == '0) begin
                            n_ctx.src_w  = clamp_side(i_in.payload.source_width);
                            n_ctx.src_h  = clamp_side(i_in.payload.source_height);
                            n_ctx.src_hx = XW'(i_in.payload.hotspot_x);
                            n_ctx.src_hy = XW'(i_in.payload.hotspot_y);
                        end
                        if (src_we) n_ctx.load_cnt = r_ctx.load_cnt + LW'(1);
                        if (i_in.payload.last_pixel) begin
                            n_ctx.load_cnt = '0;
                            n_ctx.c    = c_c;
                            n_ctx.g    = g_c;
                            n_ctx.seen = 1'b0;
                            n_ctx.minx = n_ctx.src_w;
                            n_ctx.miny = n_ctx.src_h;
                            n_ctx.maxx = '0;
                            n_ctx.maxy = '0;
                            n_ctx.sx   = '0;
                            n_ctx.sy   = '0;
                            n_ctx.addr = '0;
                            n_state    = S_SCAN_RD;
                        end
                    end else begin
                        n_ctx.rd_in  = (rd_col < r_ctx.hdr_w) && (rd_row < r_ctx.hdr_h);
                        n_ctx.rd_can = (rd_col < r_ctx.dw) && (rd_row < r_ctx.dh);
                        n_state      = S_RDOUT;
                    end
                end
            end
            S_RDOUT: begin
                n_ctx.out_valid        = 1'b1;
                n_ctx.out.result_kind  = KIND_PIXEL;
                n_ctx.out.rescaled     = r_ctx.rescaled;
                n_ctx.out.image_width  = r_ctx.hdr_w[7:0];
                n_ctx.out.image_height = r_ctx.hdr_h[7:0];
                n_ctx.out.out_hot_x    = r_ctx.hdr_hx[6:0];
                n_ctx.out.out_hot_y    = r_ctx.hdr_hy[6:0];
                if (!r_ctx.rd_in) n_ctx.out.pixel_out = '0;
                else if (r_ctx.rescaled) n_ctx.out.pixel_out = r_ctx.rd_can ? r_can_q : '0;
                else n_ctx.out.pixel_out = r_src_q;
                n_state = S_IDLE;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CK;
            end
            S_SCAN_CK: begin
                if (r_src_q[31:ALPHA_LSB] != '0) begin
                    n_ctx.seen = 1'b1;
                    if (r_ctx.sx < r_ctx.minx) n_ctx.minx = r_ctx.sx;
                    if (r_ctx.sx > r_ctx.maxx) n_ctx.maxx = r_ctx.sx;
                    if (r_ctx.sy < r_ctx.miny) n_ctx.miny = r_ctx.sy;
                    if (r_ctx.sy > r_ctx.maxy) n_ctx.maxy = r_ctx.sy;
                end
                n_ctx.addr = r_ctx.addr + AW'(1);
                n_state    = S_SCAN_RD;
                if (r_ctx.sx == r_ctx.src_w - XW'(1)) begin
                    n_ctx.sx = '0;
                    if (r_ctx.sy == r_ctx.src_h - XW'(1)) n_state = S_DECIDE;
                    else n_ctx.sy = r_ctx.sy + XW'(1);
                end else begin
                    n_ctx.sx = r_ctx.sx + XW'(1);
                end
            end
            S_DECIDE: begin
                n_ctx.rescaled = 1'b0;
                n_ctx.hdr_w    = r_ctx.src_w;
                n_ctx.hdr_h    = r_ctx.src_h;
                n_ctx.hdr_hx   = r_ctx.src_hx;
                n_ctx.hdr_hy   = r_ctx.src_hy;
                n_ctx.len      = len_c;
                if (r_ctx.g == '0 || !r_ctx.seen || len_c <= r_ctx.g) begin
                    n_state = S_HDR;
                end else begin
                    dv_go = 1'b1;
                    dv_n  = scale_num(r_ctx.src_w, r_ctx.g, len_c);
                    dv_d  = DDW'(len_c) << 1;
                    dv_r  = S_SC_H;
                end
            end
            S_DIV: begin
                n_ctx.dv_rem = dv_ge ? DDW'(dv_trial - {1'b0, r_ctx.dv_den})
                                     : dv_trial[DDW-1:0];
                n_ctx.dv_num = {r_ctx.dv_num[DNW-2:0], dv_ge};
                n_ctx.dv_cnt = r_ctx.dv_cnt + DCW'(1);
                if (r_ctx.dv_cnt == DCW'(DNW - 1)) n_state = r_ctx.ret;
            end
            S_SC_H: begin
                n_ctx.dw = fit_side(r_ctx.dv_num, r_ctx.c);
                dv_go = 1'b1;
                dv_n  = scale_num(r_ctx.src_h, r_ctx.g, r_ctx.len);
                dv_d  = DDW'(r_ctx.len) << 1;
                dv_r  = S_SC_HX;
            end
            S_SC_HX: begin
                n_ctx.dh = fit_side(r_ctx.dv_num, r_ctx.c);
                dv_go = 1'b1;
                dv_n  = scale_num(r_ctx.src_hx, r_ctx.g, r_ctx.len);
                dv_d  = DDW'(r_ctx.len) << 1;
                dv_r  = S_SC_HY;
            end
            S_SC_HY: begin
                n_ctx.hdr_hx = fit_hot(r_ctx.dv_num, r_ctx.c);
                dv_go = 1'b1;
                dv_n  = scale_num(r_ctx.src_hy, r_ctx.g, r_ctx.len);
                dv_d  = DDW'(r_ctx.len) << 1;
                dv_r  = S_FIX;
            end
            S_FIX: begin
                n_ctx.hdr_hy   = fit_hot(r_ctx.dv_num, r_ctx.c);
                n_ctx.hdr_w    = r_ctx.c;
                n_ctx.hdr_h    = r_ctx.c;
                n_ctx.rescaled = 1'b1;
                n_ctx.dy       = '0;
                n_ctx.y0raw    = '0;
                n_state        = S_ROW_Y1;
            end
            S_ROW_Y1: begin
                dv_go = 1'b1;
                dv_n  = DNW'(r_ctx.dy + XW'(1)) * DNW'(r_ctx.src_h);
                dv_d  = DDW'(r_ctx.dh);
                dv_r  = S_ROW_SET;
            end
            S_ROW_SET: begin
                n_ctx.y1raw = XW'(r_ctx.dv_num);
                n_ctx.y0    = r_ctx.y0raw;
                n_ctx.y1    = fit_bound(r_ctx.dv_num, r_ctx.y0raw, r_ctx.src_h);
                n_ctx.dx    = '0;
                n_ctx.x0raw = '0;
                n_state     = S_COL_X1;
            end
            S_COL_X1: begin
                dv_go = 1'b1;
                dv_n  = DNW'(r_ctx.dx + XW'(1)) * DNW'(r_ctx.src_w);
                dv_d  = DDW'(r_ctx.dw);
                dv_r  = S_COL_SET;
            end
            S_COL_SET: begin
                n_ctx.x1raw   = XW'(r_ctx.dv_num);
                n_ctx.x0      = r_ctx.x0raw;
                n_ctx.x1      = fit_bound(r_ctx.dv_num, r_ctx.x0raw, r_ctx.src_w);
                n_ctx.x       = r_ctx.x0raw;
                n_ctx.y       = r_ctx.y0;
                n_ctx.rowbase = AW'(r_ctx.y0) * AW'(r_ctx.src_w);
                n_ctx.acc     = '0;
                n_ctx.n       = '0;
                n_state       = S_ACC_RD;
            end
            S_ACC_RD: begin
                src_rd_addr = r_ctx.rowbase + AW'(r_ctx.x);
                n_state     = S_ACC_AD;
            end
            S_ACC_AD: begin
                for (int i = 0; i < 4; i++) begin
                    n_ctx.acc[i] = r_ctx.acc[i] + ACW'(r_src_q[8*i +: 8]);
                end
                n_ctx.n = r_ctx.n + LW'(1);
                n_state = S_ACC_RD;
                if (r_ctx.x + XW'(1) < r_ctx.x1) begin
                    n_ctx.x = r_ctx.x + XW'(1);
                end else if (r_ctx.y + XW'(1) < r_ctx.y1) begin
                    n_ctx.y       = r_ctx.y + XW'(1);
                    n_ctx.x       = r_ctx.x0;
                    n_ctx.rowbase = r_ctx.rowbase + AW'(r_ctx.src_w);
                end else begin
                    n_ctx.k = '0;
                    n_state = S_CH_DIV;
                end
            end
            S_CH_DIV: begin
                dv_go = 1'b1;
                dv_n  = DNW'(r_ctx.acc[r_ctx.k]);
                dv_d  = DDW'(r_ctx.n);
                dv_r  = S_CH_SET;
            end
            S_CH_SET: begin
                n_ctx.pix[r_ctx.k] = r_ctx.dv_num[7:0];
                if (r_ctx.k == 2'd3) begin
                    n_state = S_CAN_WR;
                end else begin
                    n_ctx.k = r_ctx.k + 2'd1;
                    n_state = S_CH_DIV;
                end
            end
            S_CAN_WR: begin
                can_we      = 1'b1;
                n_ctx.x0raw = r_ctx.x1raw;
                if (r_ctx.dx + XW'(1) < r_ctx.dw) begin
                    n_ctx.dx = r_ctx.dx + XW'(1);
                    n_state  = S_COL_X1;
                end else begin
                    n_ctx.y0raw = r_ctx.y1raw;
                    if (r_ctx.dy + XW'(1) < r_ctx.dh) begin
                        n_ctx.dy = r_ctx.dy + XW'(1);
                        n_state  = S_ROW_Y1;
                    end else begin
                        n_state = S_HDR;
                    end
                end
            end
            S_HDR: begin
                n_ctx.out_valid        = 1'b1;
                n_ctx.out.result_kind  = KIND_HEADER;
                n_ctx.out.rescaled     = r_ctx.rescaled;
                n_ctx.out.image_width  = r_ctx.hdr_w[7:0];
                n_ctx.out.image_height = r_ctx.hdr_h[7:0];
                n_ctx.out.out_hot_x    = r_ctx.hdr_hx[6:0];
                n_ctx.out.out_hot_y    = r_ctx.hdr_hy[6:0];
                n_ctx.out.pixel_out    = '0;
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (dv_go) begin
            n_ctx.dv_num = dv_n;
            n_ctx.dv_den = dv_d;
            n_ctx.dv_rem = '0;
            n_ctx.dv_cnt = '0;
            n_ctx.ret    = dv_r;
            n_state      = S_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctx    <= '0;
            r_canvas <= CANVAS_RESET;
            r_glyph  <= GLYPH_RESET;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CANVAS_SIDE: r_canvas <= i_cfg_data;
                    REG_GLYPH_SIDE:  r_glyph  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (src_we) src_mem[r_ctx.load_cnt[AW-1:0]] <= i_in.payload.source_pixel;
        r_src_q <= src_mem[src_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (can_we) can_mem[can_wr_addr] <= r_ctx.pix;
        r_can_q <= can_mem[can_rd_addr];
    end

    `CGN_ASSERT_NEXT(a_read_to_out, in_acc && i_in.payload.opcode == OP_READ, r_state == S_RDOUT, "read did not reach output stage")
    `CGN_ASSERT_NEXT(a_hdr_out, r_state == S_HDR, r_ctx.out_valid && r_ctx.out.result_kind == KIND_HEADER, "header not presented")
    `CGN_ASSERT_IMPL(a_can_in_area, r_state == S_CAN_WR, r_ctx.dx < r_ctx.dw && r_ctx.dy < r_ctx.dh, "canvas write outside scaled area")
    `CGN_ASSERT_IMPL(a_div_rem, r_state == S_DIV, r_ctx.dv_rem < r_ctx.dv_den, "divider remainder out of range")

endmodule
